// ===== rtl/core/mcrc_pkg.sv =====
// Shared types and constants for the motor current ripple counter.
package mcrc_pkg;

    localparam int ALPHA_BITS    = 16;
    localparam int BLANK_BITS    = 8;
    localparam int MUL_CNT_BITS  = $clog2(ALPHA_BITS);
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    localparam int HYST_MIN_UNITS = 5;
    localparam int DC_ONE_UNITS   = 1;

    localparam logic                  ENABLE_RST     = 1'b1;
    localparam logic [ALPHA_BITS-1:0] ALPHA_FAST_RST = 16'd655;
    localparam logic [ALPHA_BITS-1:0] ALPHA_SLOW_RST = 16'd164;
    localparam logic [ALPHA_BITS-1:0] HYST_FRAC_RST  = 16'd3277;
    localparam logic [BLANK_BITS-1:0] BLANK_TICKS_RST = 8'd5;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ENABLE      = 3'd0,
        REG_ALPHA_FAST  = 3'd1,
        REG_ALPHA_SLOW  = 3'd2,
        REG_HYST_FRAC   = 3'd3,
        REG_BLANK_TICKS = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_STEP,
        ST_HLOAD,
        ST_DETECT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/mcrc_if.sv =====
// Request and result channel interfaces of the motor current ripple counter.
interface mcrc_item_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   restart;
    logic                   drive_on;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, restart, drive_on, sample_valid, sample, input ready);
    modport sink (input valid, restart, drive_on, sample_valid, sample, output ready);
endinterface

interface mcrc_result_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_BITS-1:0]  ripple_count;
    logic                   edge_seen;
    logic                   above_level;
    logic                   blanking;
    logic [SAMPLE_BITS-1:0] dc_level;

    modport source (output valid, ripple_count, edge_seen, above_level, blanking, dc_level,
                    input ready);
    modport sink (input valid, ripple_count, edge_seen, above_level, blanking, dc_level,
                  output ready);
endinterface

// ===== rtl/core/motor_current_ripple_counter_core.sv =====
// Top level of the motor current ripple counter with its serial multiplier and APB registers.
//
//   channel  direction  handshake      payload
//   item     in         valid/ready    restart, drive_on, sample_valid, sample
//   result   out        valid/ready    ripple_count, edge_seen, above_level, blanking, dc_level
//   apb      in         psel/penable   register writes and reads, pready always high
//
// A request without a DC update runs prep and done only; a DC update adds the multiply and the
// step or a first-sample load, plus, outside blanking, the band multiply and hysteresis check.
// The shift-and-add multiplier handles one multiplier bit per cycle, serving the DC step and
// the band. Reset clears the estimate, the detector, the counter and the registers to defaults.
// A new request is taken once the previous one is finished; a stalled result is held in
// the output register while the next request is worked on.
module motor_current_ripple_counter_core
    import mcrc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    mcrc_item_if.sink                item,
    mcrc_result_if.source            result
);

    localparam int DC_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int ACC_BITS = DC_BITS + ALPHA_BITS;
    localparam logic [DC_BITS-1:0] DC_ONE   = DC_BITS'(DC_ONE_UNITS) << FRAC_BITS;
    localparam logic [DC_BITS-1:0] HYST_MIN = DC_BITS'(HYST_MIN_UNITS) << FRAC_BITS;
    localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = MUL_CNT_BITS'(ALPHA_BITS - 1);

    logic                   enable_reg;
    logic [ALPHA_BITS-1:0]  alpha_fast_reg;
    logic [ALPHA_BITS-1:0]  alpha_slow_reg;
    logic [ALPHA_BITS-1:0]  hyst_frac_reg;
    logic [BLANK_BITS-1:0]  blank_ticks_reg;
    logic                   cfg_write;
    reg_idx_t               cfg_idx;

    state_t                 state_reg, state_next;
    logic [DC_BITS-1:0]     dc_reg, dc_next;
    logic                   above_reg, above_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   drive_was_on_reg, drive_was_on_next;
    logic [BLANK_BITS-1:0]  blank_left_reg, blank_left_next;
    logic [MUL_CNT_BITS-1:0] mcnt_reg, mcnt_next;
    logic                   hyst_phase_reg, hyst_phase_next;
    logic                   fast_reg, fast_next;
    logic                   dir_up_reg, dir_up_next;
    logic                   edge_reg, edge_next;
    logic                   blank_flag_reg, blank_flag_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   drive_reg, drive_next;
    logic                   svalid_reg, svalid_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [DC_BITS-1:0]     mcand_reg, mcand_next;
    logic [ALPHA_BITS-1:0]  mult_reg, mult_next;
    logic                   out_load;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic                   out_edge_reg;
    logic                   out_above_reg;
    logic                   out_blank_reg;
    logic [SAMPLE_BITS-1:0] out_dc_reg;

    logic [DC_BITS-1:0]     s_fix;
    logic [DC_BITS-1:0]     acc_hi;
    logic [DC_BITS:0]       mul_sum;
    logic [DC_BITS:0]       step_raw;
    logic [DC_BITS-1:0]     step;
    logic [DC_BITS-1:0]     hyst;
    logic [DC_BITS:0]       low_sum;
    logic [DC_BITS:0]       high_sum;
    logic [BLANK_BITS-1:0]  blank_start;
    logic                   update_dc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:      prdata = APB_DATA_BITS'(enable_reg);
            REG_ALPHA_FAST:  prdata = APB_DATA_BITS'(alpha_fast_reg);
            REG_ALPHA_SLOW:  prdata = APB_DATA_BITS'(alpha_slow_reg);
            REG_HYST_FRAC:   prdata = APB_DATA_BITS'(hyst_frac_reg);
            REG_BLANK_TICKS: prdata = APB_DATA_BITS'(blank_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= ENABLE_RST;
            alpha_fast_reg  <= ALPHA_FAST_RST;
            alpha_slow_reg  <= ALPHA_SLOW_RST;
            hyst_frac_reg   <= HYST_FRAC_RST;
            blank_ticks_reg <= BLANK_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ENABLE:      enable_reg      <= pwdata[0];
                REG_ALPHA_FAST:  alpha_fast_reg  <= pwdata[ALPHA_BITS-1:0];
                REG_ALPHA_SLOW:  alpha_slow_reg  <= pwdata[ALPHA_BITS-1:0];
                REG_HYST_FRAC:   hyst_frac_reg   <= pwdata[ALPHA_BITS-1:0];
                REG_BLANK_TICKS: blank_ticks_reg <= pwdata[BLANK_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign item.ready = (state_reg == ST_IDLE);
    assign s_fix      = {sample_reg, {FRAC_BITS{1'b0}}};
    assign acc_hi     = acc_reg[ACC_BITS-1:ALPHA_BITS];
    assign mul_sum    = {1'b0, acc_hi} + (mult_reg[0] ? {1'b0, mcand_reg} : '0);
    assign step_raw   = {1'b0, acc_hi} + (DC_BITS + 1)'(acc_reg[ALPHA_BITS-1]);
    assign step       = (step_raw > {1'b0, mcand_reg}) ? mcand_reg : step_raw[DC_BITS-1:0];
    assign hyst       = (acc_hi < HYST_MIN) ? HYST_MIN : acc_hi;
    assign low_sum    = {1'b0, s_fix} + {1'b0, hyst};
    assign high_sum   = {1'b0, dc_reg} + {1'b0, hyst};
    assign blank_start = drive_was_on_reg ? blank_left_reg : blank_ticks_reg;

    always_comb
    begin
        state_next        = state_reg;
        dc_next           = dc_reg;
        above_next        = above_reg;
        count_next        = count_reg;
        drive_was_on_next = drive_was_on_reg;
        blank_left_next   = blank_left_reg;
        mcnt_next         = mcnt_reg;
        hyst_phase_next   = hyst_phase_reg;
        fast_next         = fast_reg;
        dir_up_next       = dir_up_reg;
        edge_next         = edge_reg;
        blank_flag_next   = blank_flag_reg;
        drive_next        = drive_reg;
        svalid_next       = svalid_reg;
        sample_next       = sample_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mult_next         = mult_reg;
        out_load          = 1'b0;
        update_dc         = 1'b0;
        out_valid_next    = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    drive_next  = item.drive_on;
                    svalid_next = item.sample_valid;
                    sample_next = item.sample;
                    if (item.restart)
                    begin
                        dc_next           = '0;
                        above_next        = 1'b0;
                        count_next        = '0;
                        drive_was_on_next = 1'b0;
                        blank_left_next   = '0;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                edge_next       = 1'b0;
                blank_flag_next = 1'b0;
                fast_next       = 1'b0;
                state_next      = ST_DONE;
                if (enable_reg)
                begin
                    if (!drive_reg)
                    begin
                        drive_was_on_next = 1'b0;
                    end
                    else
                    begin
                        drive_was_on_next = 1'b1;
                        if (blank_start != '0)
                        begin
                            blank_left_next = blank_start - 1'b1;
                            blank_flag_next = 1'b1;
                            mult_next       = alpha_slow_reg;
                        end
                        else
                        begin
                            blank_left_next = '0;
                            fast_next       = 1'b1;
                            mult_next       = alpha_fast_reg;
                        end
                        update_dc = svalid_reg;
                    end
                end
                if (update_dc)
                begin
                    if (dc_reg < DC_ONE)
                    begin
                        dc_next    = s_fix;
                        state_next = (blank_start != '0) ? ST_DONE : ST_HLOAD;
                    end
                    else
                    begin
                        dir_up_next     = (s_fix >= dc_reg);
                        mcand_next      = (s_fix >= dc_reg) ? (s_fix - dc_reg) : (dc_reg - s_fix);
                        acc_next        = '0;
                        mcnt_next       = '0;
                        hyst_phase_next = 1'b0;
                        state_next      = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next  = {mul_sum, acc_reg[ALPHA_BITS-1:1]};
                mult_next = mult_reg >> 1;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MUL_LAST)
                begin
                    state_next = hyst_phase_reg ? ST_DETECT : ST_STEP;
                end
            end
            ST_STEP:
            begin
                dc_next    = dir_up_reg ? (dc_reg + step) : (dc_reg - step);
                state_next = fast_reg ? ST_HLOAD : ST_DONE;
            end
            ST_HLOAD:
            begin
                mcand_next      = dc_reg;
                mult_next       = hyst_frac_reg;
                acc_next        = '0;
                mcnt_next       = '0;
                hyst_phase_next = 1'b1;
                state_next      = ST_MUL;
            end
            ST_DETECT:
            begin
                if (above_reg)
                begin
                    if (low_sum < {1'b0, dc_reg})
                    begin
                        above_next = 1'b0;
                    end
                end
                else if ({1'b0, s_fix} > high_sum)
                begin
                    above_next = 1'b1;
                    edge_next  = 1'b1;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dc_reg           <= '0;
            above_reg        <= 1'b0;
            count_reg        <= '0;
            drive_was_on_reg <= 1'b0;
            blank_left_reg   <= '0;
            mcnt_reg         <= '0;
            hyst_phase_reg   <= 1'b0;
            fast_reg         <= 1'b0;
            dir_up_reg       <= 1'b0;
            edge_reg         <= 1'b0;
            blank_flag_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dc_reg           <= dc_next;
            above_reg        <= above_next;
            count_reg        <= count_next;
            drive_was_on_reg <= drive_was_on_next;
            blank_left_reg   <= blank_left_next;
            mcnt_reg         <= mcnt_next;
            hyst_phase_reg   <= hyst_phase_next;
            fast_reg         <= fast_next;
            dir_up_reg       <= dir_up_next;
            edge_reg         <= edge_next;
            blank_flag_reg   <= blank_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg  <= drive_next;
        svalid_reg <= svalid_next;
        sample_reg <= sample_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mult_reg   <= mult_next;
        if (out_load)
        begin
            out_count_reg <= count_reg;
            out_edge_reg  <= edge_reg;
            out_above_reg <= above_reg;
            out_blank_reg <= blank_flag_reg;
            out_dc_reg    <= dc_reg[DC_BITS-1:FRAC_BITS];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.ripple_count = out_count_reg;
    assign result.edge_seen    = out_edge_reg;
    assign result.above_level  = out_above_reg;
    assign result.blanking     = out_blank_reg;
    assign result.dc_level     = out_dc_reg;

    a_edge_sets_above: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.edge_seen |-> result.above_level)
        else $error("Counted edge without the detector above the band.");

    a_edge_not_blanked: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.edge_seen && result.blanking))
        else $error("Edge counted during blanking.");

    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == ST_DETECT)
                                || $past(state_reg == ST_IDLE && item.valid))
        else $error("Ripple count changed outside detection or restart.");

    a_mul_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_MUL |-> mcnt_reg == '0)
        else $error("Multiplier step count left nonzero.");

endmodule

// ===== test/tb_motor_current_ripple_counter_core.sv =====
// Self-checking testbench: directed and random current ticks through the core, checked per field.
module tb_motor_current_ripple_counter_core
    import mcrc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = 12;
    localparam int FRAC_BITS    = 16;
    localparam int COUNT_BITS   = 16;
    localparam int DC_BITS      = SAMPLE_BITS + FRAC_BITS;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 600;
    localparam int LONG_HOLD_AT = 300;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 60;

    localparam logic [DC_BITS-1:0] DC_ONE   = DC_BITS'(DC_ONE_UNITS) << FRAC_BITS;
    localparam logic [DC_BITS+1:0] HYST_MIN = (DC_BITS+2)'(HYST_MIN_UNITS) << FRAC_BITS;

    typedef struct packed {
        logic                   restart;
        logic                   drive_on;
        logic                   sample_valid;
        logic [SAMPLE_BITS-1:0] sample;
    } tick_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  ripple_count;
        logic                   edge_seen;
        logic                   above_level;
        logic                   blanking;
        logic [SAMPLE_BITS-1:0] dc_level;
    } ripple_out_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    mcrc_item_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
    mcrc_result_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) res_bus ();

    motor_current_ripple_counter_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .item   (req_bus),
        .result (res_bus)
    );

    // Predictor copy of the registers and of the detector state.
    logic                  cfg_enable;
    logic [15:0]           cfg_alpha_fast;
    logic [15:0]           cfg_alpha_slow;
    logic [15:0]           cfg_hyst_frac;
    logic [7:0]            cfg_blank_ticks;
    logic [DC_BITS-1:0]    est_dc;
    logic                  est_above;
    logic [COUNT_BITS-1:0] est_count;
    logic                  est_drive_was_on;
    logic [7:0]            est_blank_left;

    tick_t       tick_queue[$];
    ripple_out_t predicted_ticks[$];
    tick_t       next_tick;
    ripple_out_t want;

    int  err_cnt       = 0;
    int  tx_gap        = 0;
    int  rx_stall      = 0;
    int  results_seen  = 0;
    int  quiet_cycles  = 0;
    bit  long_hold_done = 1'b0;
    bit  idle_on       = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
        if (got !== exp)
        begin
            report($sformatf("%s is %0h, predicted %0h", name, got, exp));
        end
    endtask

    function automatic logic [DC_BITS-1:0] dc_follow(input logic [DC_BITS-1:0] dc,
                                                     input logic [DC_BITS-1:0] target,
                                                     input logic [15:0] alpha);
        logic [DC_BITS-1:0] diff;
        logic [44:0]        prod;
        logic [28:0]        step;
        if (dc < DC_ONE)
        begin
            return target;
        end
        diff = (target >= dc) ? target - dc : dc - target;
        prod = alpha * diff + 45'd32768;
        step = prod[44:16];
        if (step > diff)
        begin
            step = diff;
        end
        return (target >= dc) ? dc + step[DC_BITS-1:0] : dc - step[DC_BITS-1:0];
    endfunction

    function automatic ripple_out_t predict_ripple_tick(input logic restart, input logic drive_on,
                                                        input logic sample_valid,
                                                        input logic [SAMPLE_BITS-1:0] sample);
        logic [DC_BITS-1:0] s_fix;
        logic [43:0]        band_prod;
        logic [DC_BITS+1:0] band;
        ripple_out_t        o;
        s_fix = {sample, {FRAC_BITS{1'b0}}};
        o = '0;
        if (restart)
        begin
            est_dc = '0;
            est_above = 1'b0;
            est_count = '0;
            est_drive_was_on = 1'b0;
            est_blank_left = '0;
        end
        if (cfg_enable)
        begin
            if (!drive_on)
            begin
                est_drive_was_on = 1'b0;
            end
            else
            begin
                if (!est_drive_was_on)
                begin
                    est_drive_was_on = 1'b1;
                    est_blank_left = cfg_blank_ticks;
                end
                if (est_blank_left != 0)
                begin
                    est_blank_left = est_blank_left - 1'b1;
                    o.blanking = 1'b1;
                    if (sample_valid)
                    begin
                        est_dc = dc_follow(est_dc, s_fix, cfg_alpha_slow);
                    end
                end
                else if (sample_valid)
                begin
                    est_dc = dc_follow(est_dc, s_fix, cfg_alpha_fast);
                    band_prod = est_dc * cfg_hyst_frac;
                    band = (DC_BITS+2)'(band_prod[43:16]);
                    if (band < HYST_MIN)
                    begin
                        band = HYST_MIN;
                    end
                    if (est_above)
                    begin
                        if ((DC_BITS+2)'(s_fix) + band < (DC_BITS+2)'(est_dc))
                        begin
                            est_above = 1'b0;
                        end
                    end
                    else if ((DC_BITS+2)'(s_fix) > (DC_BITS+2)'(est_dc) + band)
                    begin
                        est_above = 1'b1;
                        o.edge_seen = 1'b1;
                        if (est_count != {COUNT_BITS{1'b1}})
                        begin
                            est_count = est_count + 1'b1;
                        end
                    end
                end
            end
        end
        o.ripple_count = est_count;
        o.above_level = est_above;
        o.dc_level = est_dc[DC_BITS-1:FRAC_BITS];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic tick_t make_tick(input logic restart, input logic drive_on,
                                        input logic sample_valid, input int level);
        tick_t t;
        t.restart = restart;
        t.drive_on = drive_on;
        t.sample_valid = sample_valid;
        t.sample = (level < 0) ? '0 : (level > 4095) ? 12'hFFF : SAMPLE_BITS'(level);
        return t;
    endfunction

    // A movement opens with a tick that usually restarts, then a current wave around a DC level with PWM off pulses.
    task automatic add_movement(input int len);
        int level;
        int amp;
        int period;
        int s;
        level = $urandom_range(0, 4095);
        amp = $urandom_range(0, 400);
        period = $urandom_range(2, 10);
        tick_queue.push_back(make_tick($urandom_range(0, 3) != 0, 1'b1, 1'b1, level));
        for (int i = 1; i < len; i++)
        begin
            s = level + (((i % period) < (period / 2)) ? amp : -amp)
                + int'($urandom_range(0, 8)) - 4;
            tick_queue.push_back(make_tick($urandom_range(0, 299) == 0,
                                           $urandom_range(0, 99) >= 6,
                                           $urandom_range(0, 24) != 0, s));
        end
    endtask

    task automatic add_random(input int n);
        int added;
        int len;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    tick_queue.push_back(make_tick($urandom_range(0, 7) == 0,
                                                   1'($urandom_range(0, 1)),
                                                   1'($urandom_range(0, 1)),
                                                   $urandom_range(0, 4095)));
                end
            end
            else
            begin
                len = $urandom_range(20, 80);
                add_movement(len);
            end
            added += len;
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLE:      cfg_enable = value[0];
            REG_ALPHA_FAST:  cfg_alpha_fast = value[15:0];
            REG_ALPHA_SLOW:  cfg_alpha_slow = value[15:0];
            REG_HYST_FRAC:   cfg_hyst_frac = value[15:0];
            REG_BLANK_TICKS: cfg_blank_ticks = value[7:0];
            default:         ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [15:0] af, input logic [15:0] as,
                              input logic [15:0] hf, input logic [7:0] bt);
        write_reg(REG_ENABLE, APB_DATA_BITS'(en));
        write_reg(REG_ALPHA_FAST, APB_DATA_BITS'(af));
        write_reg(REG_ALPHA_SLOW, APB_DATA_BITS'(as));
        write_reg(REG_HYST_FRAC, APB_DATA_BITS'(hf));
        write_reg(REG_BLANK_TICKS, APB_DATA_BITS'(bt));
    endtask

    // The queues and the valid line are sampled between edges so that no request is missed.
    task automatic drain();
        @(negedge clk);
        while (tick_queue.size() != 0 || req_bus.valid || predicted_ticks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                predicted_ticks.push_back(predict_ripple_tick(req_bus.restart, req_bus.drive_on,
                                                              req_bus.sample_valid,
                                                              req_bus.sample));
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    next_tick = tick_queue.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.restart <= next_tick.restart;
                    req_bus.drive_on <= next_tick.drive_on;
                    req_bus.sample_valid <= next_tick.sample_valid;
                    req_bus.sample <= next_tick.sample;
                    if (idle_on)
                    begin
                        tx_gap <= pick_gap();
                    end
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (predicted_ticks.size() == 0)
                begin
                    report($sformatf("result with no request pending, count %0h",
                                     res_bus.ripple_count));
                end
                else
                begin
                    want = predicted_ticks.pop_front();
                    check_field("ripple_count", 32'(res_bus.ripple_count),
                                32'(want.ripple_count));
                    check_field("edge_seen", 32'(res_bus.edge_seen), 32'(want.edge_seen));
                    check_field("above_level", 32'(res_bus.above_level), 32'(want.above_level));
                    check_field("blanking", 32'(res_bus.blanking), 32'(want.blanking));
                    check_field("dc_level", 32'(res_bus.dc_level), 32'(want.dc_level));
                end
                results_seen <= results_seen + 1;
            end
            if (!long_hold_done && results_seen == LONG_HOLD_AT)
            begin
                long_hold_done <= 1'b1;
                rx_stall <= LONG_HOLD;
                res_bus.ready <= 1'b0;
            end
            else if (rx_stall != 0)
            begin
                rx_stall <= rx_stall - 1;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (idle_on)
                begin
                    rx_stall <= pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles == STALL_LIMIT)
            begin
                report("no request or result has moved for too long");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.restart = 1'b0;
        req_bus.drive_on = 1'b0;
        req_bus.sample_valid = 1'b0;
        req_bus.sample = '0;
        res_bus.ready = 1'b0;
        cfg_enable = ENABLE_RST;
        cfg_alpha_fast = ALPHA_FAST_RST;
        cfg_alpha_slow = ALPHA_SLOW_RST;
        cfg_hyst_frac = HYST_FRAC_RST;
        cfg_blank_ticks = BLANK_TICKS_RST;
        est_dc = '0;
        est_above = 1'b0;
        est_count = '0;
        est_drive_was_on = 1'b0;
        est_blank_left = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: first-sample load, blanking with invalid samples, crossings, drive off.
        tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 0));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 123));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 2000));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 2000));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 2000));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 0));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 0));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 1));
        for (int i = 0; i < 5; i++)
        begin
            tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 0));
        end
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 0));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 4095));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 2730));
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 1365));
        add_random(480);
        drain();

        idle_on = 1'b0;
        set_config(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 8'd0);
        add_random(300);
        drain();

        idle_on = 1'b1;
        set_config(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd255);
        add_random(200);
        drain();

        set_config(1'b0, 16'd900, 16'd200, 16'd2000, 8'd3);
        add_random(60);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            set_config(1'b1, 16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 13000)), 8'($urandom_range(0, 12)));
            add_random(250);
            drain();
        end

        repeat (TAIL) @(posedge clk);
        if (predicted_ticks.size() != 0)
        begin
            report($sformatf("%0d predicted results never arrived", predicted_ticks.size()));
        end
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mcrc_pkg.sv
rtl/core/mcrc_if.sv
rtl/core/motor_current_ripple_counter_core.sv
test/tb_motor_current_ripple_counter_core.sv
